/* design/b85_pkg.sv */
// shared constants and types of the base-85 stream encoder
package b85_pkg;

    localparam logic [6:0]  B85_BASE      = 7'd85;
    localparam logic [6:0]  B85_OFFSET    = 7'd33;
    localparam logic [6:0]  B85_ZERO_CHAR = 7'd122;

    // floor(w / 85) == (w * B85_RECIP) >> B85_RECIP_SHIFT for every 32-bit w
    localparam logic [31:0] B85_RECIP       = 32'hC0C0C0C1;
    localparam int unsigned B85_RECIP_SHIFT = 38;

    localparam int unsigned GRP_FIFO_DEPTH = 4;
    localparam int unsigned GRP_FIFO_AW    = $clog2(GRP_FIFO_DEPTH);

    // one group to encode, as handed from the front end to the back end
    typedef struct packed {
        logic [31:0] word;     // big-endian group, tail zero-padded
        logic        extra_z;  // stream ended on a full group: append a 'z'
        logic        is_end;   // group closes the stream
    } t_group;

endpackage

/* design/base85_stream_encoder.sv */
// top level of the base-85 stream encoder
//
// input side is a queue write port: a byte beat (i_data_byte, i_is_final) is
// taken at a rising edge with push high and full low. i_is_final marks the last
// byte of a stream; the next byte starts a new stream.
// output side is a queue read port: while empty is low the oldest character is
// on o_out_char with o_run_last (last character caused by its input byte) and
// o_stream_end (last character of the encoded stream); pop takes the beat.
// bytes are packed big-endian into 32-bit groups; a finished group goes into a
// four-deep group queue, so bytes keep being taken while the back end works.
// the back end divides a nonzero group by 85 in five steps through one
// reciprocal multiplier, holding the converter meanwhile; an all-zero group
// skips conversion and becomes one 'z'. characters leave at up to one per
// cycle while pop is high; sustained input is one byte per cycle until the
// group queue fills, after which intake runs at the pace of the back end.
// when pop stays low the output register holds its beat, the sequencer and
// converter back up behind it, and full rises once the group queue is full.
// synchronous reset empties the queue and clears all partial groups.
module base85_stream_encoder
    import b85_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_final,
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  o_out_char,
    output logic        o_run_last,
    output logic        o_stream_end
);

    // group beats between front end, queue and back end
    logic   fifo_wr;
    logic   fifo_full;
    logic   fifo_valid;
    logic   fifo_pop;
    t_group front_grp;
    t_group head_grp;

    // byte packing
    b85_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_is_final  (i_is_final),
        .i_fifo_full (fifo_full),
        .o_full      (full),
        .o_wr        (fifo_wr),
        .o_grp       (front_grp)
    );

    // decouples byte intake from character output
    b85_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fifo_wr),
        .i_grp   (front_grp),
        .i_pop   (fifo_pop),
        .o_full  (fifo_full),
        .o_valid (fifo_valid),
        .o_grp   (head_grp)
    );

    // digit conversion and character output
    b85_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (fifo_valid),
        .i_grp        (head_grp),
        .o_pop        (fifo_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_char   (o_out_char),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end)
    );

    // a group is never written into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_wr && fifo_full))
        else $error("group queue overflow");

    // the back end only takes a group that is there
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_pop |-> fifo_valid)
        else $error("group queue underflow");

    // every shown character is a digit character or 'z'
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_out_char >= B85_OFFSET
                     && o_out_char <= (B85_OFFSET + B85_BASE - 7'd1))
                    || o_out_char == B85_ZERO_CHAR))
        else $error("character out of range");

    // end of stream is always the last character of its byte
    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_stream_end) |-> o_run_last)
        else $error("stream end without run last");

endmodule

/* design/b85_front.sv */
// front end: packs bytes into 32-bit groups and queues finished groups
module b85_front
    import b85_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_final,
    input  logic        i_fifo_full,
    output logic        o_full,
    output logic        o_wr,
    output t_group      o_grp
);

    logic [23:0] r_held;
    logic [1:0]  r_count;
    logic [23:0] n_held;
    logic [1:0]  n_count;
    logic        accept;
    logic        grp_done;
    logic [31:0] padded;

    assign o_full   = i_fifo_full;
    assign accept   = i_push & ~i_fifo_full;
    assign grp_done = (r_count == 2'd3) | i_is_final;

    // place the held bytes and the new byte at the top of the word
    always_comb begin
        unique case (r_count)
            2'd0: padded = {i_data_byte, 24'h000000};
            2'd1: padded = {r_held[7:0], i_data_byte, 16'h0000};
            2'd2: padded = {r_held[15:0], i_data_byte, 8'h00};
            2'd3: padded = {r_held, i_data_byte};
            default: padded = {r_held, i_data_byte};
        endcase
    end

    assign o_wr          = accept & grp_done;
    assign o_grp.word    = padded;
    assign o_grp.extra_z = (r_count == 2'd3) & i_is_final;
    assign o_grp.is_end  = i_is_final;

    always_comb begin
        n_held  = r_held;
        n_count = r_count;
        if (accept) begin
            if (grp_done) begin
                n_held  = '0;
                n_count = '0;
            end else begin
                n_held  = {r_held[15:0], i_data_byte};
                n_count = r_count + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_count <= '0;
        end else begin
            r_held  <= n_held;
            r_count <= n_count;
        end
    end

endmodule

/* design/b85_fifo.sv */
// short group queue between front end and back end
module b85_fifo
    import b85_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_group  i_grp,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_group  o_grp
);

    localparam logic [GRP_FIFO_AW:0] FifoDepthCnt = (GRP_FIFO_AW + 1)'(GRP_FIFO_DEPTH);
    localparam logic [GRP_FIFO_AW-1:0] FifoLastIdx = GRP_FIFO_AW'(GRP_FIFO_DEPTH - 1);

    t_group                 r_mem [GRP_FIFO_DEPTH];
    logic [GRP_FIFO_AW-1:0] r_wr_ptr;
    logic [GRP_FIFO_AW-1:0] r_rd_ptr;
    logic [GRP_FIFO_AW:0]   r_cnt;

    assign o_full  = (r_cnt == FifoDepthCnt);
    assign o_valid = (r_cnt != '0);
    assign o_grp   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == FifoLastIdx) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == FifoLastIdx) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* design/b85_back.sv */
// back end: base-85 digit conversion, character sequencing, output register
module b85_back
    import b85_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_group      i_grp,
    output logic        o_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [6:0]  o_out_char,
    output logic        o_run_last,
    output logic        o_stream_end
);

    typedef enum logic [2:0] {
        CV_IDLE = 3'b001,
        CV_RUN  = 3'b010,
        CV_DONE = 3'b100
    } t_cv_state;

    // converter
    t_cv_state   r_cv_state;
    logic [2:0]  r_step;
    logic [31:0] r_q;
    logic [31:0] r_wp;
    logic [6:0]  r_dig [5];
    t_group      r_cv_grp;

    logic [63:0] quot_prod;
    logic [31:0] quot;
    logic [13:0] back_prod;
    logic [6:0]  rem;
    logic        cv_free;

    // character sequencer
    logic        r_em_valid;
    logic [6:0]  r_em_chars [6];
    logic [2:0]  r_em_left;
    logic        r_em_end;
    logic        em_last;
    logic        em_load;

    // output register
    logic        r_out_valid;
    logic [6:0]  r_out_char;
    logic        r_out_run_last;
    logic        r_out_stream_end;
    logic        out_take;
    logic        out_load;

    // one divide-by-85 step: reciprocal multiply, remainder from low bits only
    assign quot_prod = 64'(r_q) * 64'(B85_RECIP);
    assign quot      = 32'(quot_prod >> B85_RECIP_SHIFT);
    assign back_prod = r_q[6:0] * B85_BASE;
    assign rem       = r_wp[6:0] - back_prod[6:0];

    assign out_take = i_pop & r_out_valid;
    assign out_load = r_em_valid & (~r_out_valid | out_take);
    assign em_last  = (r_em_left == 3'd1);
    assign em_load  = (r_cv_state == CV_DONE) & (~r_em_valid | (out_load & em_last));
    assign cv_free  = (r_cv_state == CV_IDLE) | ((r_cv_state == CV_DONE) & em_load);
    assign o_pop    = i_valid & cv_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv_state <= CV_IDLE;
            r_step     <= '0;
        end else begin
            if (o_pop) begin
                r_step     <= '0;
                r_cv_state <= (i_grp.word == '0) ? CV_DONE : CV_RUN;
            end else begin
                unique case (r_cv_state)
                    CV_IDLE: begin
                        r_cv_state <= CV_IDLE;
                    end
                    CV_RUN: begin
                        r_step <= r_step + 3'd1;
                        if (r_step == 3'd4) begin
                            r_cv_state <= CV_DONE;
                        end
                    end
                    CV_DONE: begin
                        if (em_load) begin
                            r_cv_state <= CV_IDLE;
                        end
                    end
                    default: r_cv_state <= CV_IDLE;
                endcase
            end
        end
    end

    // digits come out least significant first, stored by weight
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cv_grp <= i_grp;
            r_q      <= i_grp.word;
            if (i_grp.word == '0) begin
                for (int i = 0; i < 5; i++) begin
                    r_dig[i] <= '0;
                end
            end
        end else if (r_cv_state == CV_RUN) begin
            r_q  <= quot;
            r_wp <= r_q;
            if (r_step != 3'd0) begin
                r_dig[3'd5 - r_step] <= rem;
            end
            if (r_step == 3'd4) begin
                r_dig[0] <= r_q[6:0];
            end
        end
    end

    // character sequencer: shifts out the characters of one group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid <= 1'b0;
            r_em_left  <= '0;
        end else if (em_load) begin
            r_em_valid <= 1'b1;
            if (r_cv_grp.word == '0) begin
                r_em_left <= r_cv_grp.extra_z ? 3'd2 : 3'd1;
            end else begin
                r_em_left <= r_cv_grp.extra_z ? 3'd6 : 3'd5;
            end
        end else if (out_load) begin
            r_em_left <= r_em_left - 3'd1;
            if (em_last) begin
                r_em_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_load) begin
            r_em_end <= r_cv_grp.is_end;
            if (r_cv_grp.word == '0) begin
                r_em_chars[0] <= B85_ZERO_CHAR;
                r_em_chars[1] <= B85_ZERO_CHAR;
                for (int i = 2; i < 6; i++) begin
                    r_em_chars[i] <= B85_ZERO_CHAR;
                end
            end else begin
                for (int i = 0; i < 5; i++) begin
                    r_em_chars[i] <= r_dig[i] + B85_OFFSET;
                end
                r_em_chars[5] <= B85_ZERO_CHAR;
            end
        end else if (out_load) begin
            for (int i = 0; i < 5; i++) begin
                r_em_chars[i] <= r_em_chars[i + 1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_char       <= r_em_chars[0];
            r_out_run_last   <= em_last;
            r_out_stream_end <= em_last & r_em_end;
        end
    end

    assign o_empty      = ~r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_run_last   = r_out_run_last;
    assign o_stream_end = r_out_stream_end;

endmodule
